@@ rtl/zpv_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, codes and lane handshake types of the z-score profile verifier.
package zpv_pkg;

  localparam int MaxSamplesDef = 256;
  localparam int MeanW  = 20;
  localparam int ScoreW = 24;
  localparam int TotW   = 25;
  localparam int CntW   = 9;
  localparam logic [TotW-1:0] ThrResetVal = 25'd768;

  // Input item kinds; the lanes use the same codes as their operation.
  localparam logic [1:0] KIND_TRAIN  = 2'd0;
  localparam logic [1:0] KIND_FIN    = 2'd1;
  localparam logic [1:0] KIND_VERIFY = 2'd2;

  // Result status codes.
  localparam logic [1:0] STAT_TAKEN   = 2'd0;
  localparam logic [1:0] STAT_BUILT   = 2'd1;
  localparam logic [1:0] STAT_SCORED  = 2'd2;
  localparam logic [1:0] STAT_DROPPED = 2'd3;

  typedef struct packed {
    logic        start;
    logic [1:0]  op;
    logic [15:0] x;
  } lane_cmd_t;

  typedef struct packed {
    logic              done;
    logic [ScoreW-1:0] score;
  } lane_rsp_t;

  typedef struct packed {
    logic            load;
    logic [1:0]      status;
    logic [CntW-1:0] count;
  } mrg_req_t;

endpackage

@@ rtl/zpv_ifs.sv @@
`timescale 1ns / 1ps
// Channel interfaces of the verifier: input items, result items and the threshold write.
interface zpv_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] dwell_ms;
  logic [15:0] flight_ms;
  modport source (output valid, kind, dwell_ms, flight_ms, input ready);
  modport sink (input valid, kind, dwell_ms, flight_ms, output ready);
endinterface

interface zpv_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [23:0] dwell_deviation;
  logic [23:0] flight_deviation;
  logic [24:0] total_score;
  logic        accepted;
  logic [8:0]  sample_count;
  modport source (output valid, status, dwell_deviation, flight_deviation, total_score,
                  accepted, sample_count, input ready);
  modport sink (input valid, status, dwell_deviation, flight_deviation, total_score,
                accepted, sample_count, output ready);
endinterface

interface zpv_cfg_if;
  logic        valid;
  logic        ready;
  logic [24:0] accept_threshold;
  modport source (output valid, accept_threshold, input ready);
  modport sink (input valid, accept_threshold, output ready);
endinterface

@@ rtl/zpv_lane.sv @@
`timescale 1ns / 1ps
// One feature lane: accumulators, profile, serial multiplier, divider and square root.
module zpv_lane
  import zpv_pkg::*;
#(
  parameter int CW = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  lane_cmd_t     cmd,
  input  logic [CW-1:0] n,
  output lane_rsp_t     rsp
);

  localparam int SW     = 16 + CW;
  localparam int QW     = 32 + CW;
  localparam int PW     = CW + QW;
  localparam int NW     = PW + 8;
  localparam int DVW    = (2 * CW > MeanW) ? 2 * CW : MeanW;
  localparam int KW     = $clog2(NW + 1);
  localparam int RSTEPS = (NW + 1) / 2;

  localparam logic [2:0] L_IDLE = 3'd0;
  localparam logic [2:0] L_MEAN = 3'd1;
  localparam logic [2:0] L_MUL  = 3'd2;
  localparam logic [2:0] L_PREP = 3'd3;
  localparam logic [2:0] L_VAR  = 3'd4;
  localparam logic [2:0] L_ROOT = 3'd5;
  localparam logic [2:0] L_VDIV = 3'd6;

  logic [2:0]        st_r;
  logic [SW-1:0]     s1_r;
  logic [QW-1:0]     s2_r;
  logic [MeanW-1:0]  mean_r, spread_r;
  logic [CW-1:0]     n_r, mp_r;
  logic [KW-1:0]     cnt_r;
  logic [NW-1:0]     dvd_r, v_r, root_r, bit_r;
  logic [DVW-1:0]    rem_r, dvs_r;
  logic [PW-1:0]     mc_r, prod_r, sq_r;
  logic [2*CW-1:0]   nn_r;
  logic [ScoreW-1:0] score_r;
  logic              done_r;

  logic [31:0]       xsq;
  logic [2*SW-1:0]   s1sq;
  logic [2*CW-1:0]   nn_c;
  logic [MeanW-1:0]  v16, delta;
  logic [DVW:0]      trial;
  logic              ge;
  logic [DVW-1:0]    rem_n;
  logic [NW-1:0]     dvd_n;
  logic [NW:0]       rsum;
  logic              take;
  logic [NW-1:0]     v_n, root_n;

  always_comb begin
    xsq   = cmd.x * cmd.x;
    s1sq  = s1_r * s1_r;
    nn_c  = n_r * (n_r - 1'b1);
    v16   = {cmd.x, 4'b0};
    delta = (v16 >= mean_r) ? v16 - mean_r : mean_r - v16;
    // Restoring division, one quotient bit per cycle.
    trial = {rem_r, dvd_r[NW-1]};
    ge    = trial >= {1'b0, dvs_r};
    rem_n = ge ? DVW'(trial - {1'b0, dvs_r}) : trial[DVW-1:0];
    dvd_n = {dvd_r[NW-2:0], ge};
    // Digit-by-digit square root, one result bit per cycle.
    rsum   = {1'b0, root_r} + {1'b0, bit_r};
    take   = {1'b0, v_r} >= rsum;
    v_n    = take ? v_r - rsum[NW-1:0] : v_r;
    root_n = take ? (root_r >> 1) + bit_r : root_r >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= L_IDLE;
      done_r   <= 1'b0;
      s1_r     <= '0;
      s2_r     <= '0;
      mean_r   <= '0;
      spread_r <= '0;
      score_r  <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        L_IDLE: begin
          if (cmd.start) begin
            n_r <= n;
            case (cmd.op)
              KIND_TRAIN: begin
                s1_r   <= s1_r + SW'(cmd.x);
                s2_r   <= s2_r + QW'(xsq);
                done_r <= 1'b1;
              end
              KIND_FIN: begin
                if (n == '0) begin
                  mean_r   <= '0;
                  spread_r <= '0;
                  s1_r     <= '0;
                  s2_r     <= '0;
                  done_r   <= 1'b1;
                end else begin
                  dvd_r <= NW'({s1_r, 4'b0}) << (NW - SW - 4);
                  rem_r <= '0;
                  dvs_r <= DVW'(n);
                  cnt_r <= KW'(SW + 4);
                  st_r  <= L_MEAN;
                end
              end
              KIND_VERIFY: begin
                if (spread_r == '0) begin
                  score_r <= ScoreW'(delta);
                  done_r  <= 1'b1;
                end else begin
                  dvd_r <= NW'({delta, 8'b0}) << (NW - MeanW - 8);
                  rem_r <= '0;
                  dvs_r <= DVW'(spread_r);
                  cnt_r <= KW'(MeanW + 8);
                  st_r  <= L_VDIV;
                end
              end
              default: ;
            endcase
          end
        end
        L_MEAN: begin
          dvd_r <= dvd_n;
          rem_r <= rem_n;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == KW'(1)) begin
            mean_r <= dvd_n[MeanW-1:0];
            if (n_r < CW'(2)) begin
              spread_r <= '0;
              s1_r     <= '0;
              s2_r     <= '0;
              done_r   <= 1'b1;
              st_r     <= L_IDLE;
            end else begin
              mc_r   <= PW'(s2_r);
              mp_r   <= n_r;
              prod_r <= '0;
              sq_r   <= PW'(s1sq);
              nn_r   <= nn_c;
              cnt_r  <= KW'(CW);
              st_r   <= L_MUL;
            end
          end
        end
        L_MUL: begin
          if (mp_r[0]) prod_r <= prod_r + mc_r;
          mc_r  <= mc_r << 1;
          mp_r  <= mp_r >> 1;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == KW'(1)) st_r <= L_PREP;
        end
        L_PREP: begin
          dvd_r <= {prod_r - sq_r, 8'b0};
          rem_r <= '0;
          dvs_r <= DVW'(nn_r);
          cnt_r <= KW'(NW);
          st_r  <= L_VAR;
        end
        L_VAR: begin
          dvd_r <= dvd_n;
          rem_r <= rem_n;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == KW'(1)) begin
            v_r    <= dvd_n;
            root_r <= '0;
            bit_r  <= NW'(1) << (2 * (RSTEPS - 1));
            cnt_r  <= KW'(RSTEPS);
            st_r   <= L_ROOT;
          end
        end
        L_ROOT: begin
          v_r    <= v_n;
          root_r <= root_n;
          bit_r  <= bit_r >> 2;
          cnt_r  <= cnt_r - 1'b1;
          if (cnt_r == KW'(1)) begin
            spread_r <= root_n[MeanW-1:0];
            s1_r     <= '0;
            s2_r     <= '0;
            done_r   <= 1'b1;
            st_r     <= L_IDLE;
          end
        end
        L_VDIV: begin
          dvd_r <= dvd_n;
          rem_r <= rem_n;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == KW'(1)) begin
            score_r <= (dvd_n > NW'({ScoreW{1'b1}})) ? {ScoreW{1'b1}} : dvd_n[ScoreW-1:0];
            done_r  <= 1'b1;
            st_r    <= L_IDLE;
          end
        end
        default: st_r <= L_IDLE;
      endcase
    end
  end

  assign rsp.done  = done_r;
  assign rsp.score = score_r;

endmodule

@@ rtl/zpv_merge.sv @@
`timescale 1ns / 1ps
// Merge stage: adds the lane scores, compares with the threshold and holds the result item.
module zpv_merge
  import zpv_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  mrg_req_t          req,
  input  logic [ScoreW-1:0] dwell_score,
  input  logic [ScoreW-1:0] flight_score,
  input  logic [TotW-1:0]   threshold,
  output logic              can_load,
  zpv_out_if.source         out_ch
);

  logic              valid_r;
  logic [1:0]        status_r;
  logic [ScoreW-1:0] dd_r, fd_r;
  logic [TotW-1:0]   tot_r;
  logic              acc_r;
  logic [CntW-1:0]   cnt_r;
  logic [TotW-1:0]   tot;
  logic              scored;

  assign scored   = req.status == STAT_SCORED;
  assign tot      = TotW'(dwell_score) + TotW'(flight_score);
  assign can_load = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (req.load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.load) begin
      status_r <= req.status;
      cnt_r    <= req.count;
      dd_r     <= scored ? dwell_score : '0;
      fd_r     <= scored ? flight_score : '0;
      tot_r    <= scored ? tot : '0;
      acc_r    <= scored && (tot <= threshold);
    end
  end

  assign out_ch.valid            = valid_r;
  assign out_ch.status           = status_r;
  assign out_ch.dwell_deviation  = dd_r;
  assign out_ch.flight_deviation = fd_r;
  assign out_ch.total_score      = tot_r;
  assign out_ch.accepted         = acc_r;
  assign out_ch.sample_count     = cnt_r;

endmodule

@@ rtl/zscore_profile_verifier_core.sv @@
`timescale 1ns / 1ps
// Top level of the two-feature z-score profile verifier.
//
// The block learns a typing profile from training items and scores verify items
// against it. Dwell and flight times are handled by two identical lanes that run
// side by side; each lane owns its running sums, its mean and deviation, and a
// serial multiplier, restoring divider and square-root unit. A merge stage adds
// the two scores, compares the total with accept_threshold and holds the result
// item in an output register, so a new item is taken while a result still waits.
// One item is in work at a time; the next item can be taken in the cycle after the
// result is loaded. A training item only adds to the running sums, a dropped
// training sample starts no lane, and a verify item against a zero deviation skips
// the divider; any other verify item goes through the 28-step lane divider. A
// finalize item runs mean division, serial multiply, variance division and square
// root, one bit per cycle each; with no samples it clears the profile, and with
// one sample it stops after the mean division.
// Training items arriving after MAX_SAMPLES samples are dropped with status 3.
// The threshold port is always ready and should be written only while idle.
module zscore_profile_verifier_core
  import zpv_pkg::*;
#(
  parameter int MAX_SAMPLES = MaxSamplesDef
) (
  input  logic       clk,
  input  logic       rst_n,
  zpv_in_if.sink     in_ch,
  zpv_out_if.source  out_ch,
  zpv_cfg_if.sink    cfg_ch
);

  localparam int CW = $clog2(MAX_SAMPLES + 1);

  logic [TotW-1:0] thr_r;
  logic [CW-1:0]   acc_cnt_r, prof_cnt_r;
  logic            busy_r;
  logic [1:0]      ldone_r;
  logic [1:0]      status_r;
  logic [CntW-1:0] cnt_out_r;

  logic       in_acc, full, finish, can_load;
  lane_cmd_t  cmd_d, cmd_f;
  lane_rsp_t  rsp_d, rsp_f;
  mrg_req_t   mreq;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !busy_r;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign full         = acc_cnt_r >= CW'(MAX_SAMPLES);

  // Both lanes start together; a dropped sample and the unused kind start nothing.
  always_comb begin
    cmd_d.start = in_acc && (in_ch.kind == KIND_FIN || in_ch.kind == KIND_VERIFY ||
                             (in_ch.kind == KIND_TRAIN && !full));
    cmd_d.op    = in_ch.kind;
    cmd_d.x     = in_ch.dwell_ms;
    cmd_f       = cmd_d;
    cmd_f.x     = in_ch.flight_ms;
  end

  // The result is handed over once both lanes are done and the output register is free or being read.
  assign finish       = busy_r && (ldone_r == 2'b11) && can_load;
  assign mreq.load    = finish;
  assign mreq.status  = status_r;
  assign mreq.count   = cnt_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r      <= ThrResetVal;
      acc_cnt_r  <= '0;
      prof_cnt_r <= '0;
      busy_r     <= 1'b0;
      ldone_r    <= '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) thr_r <= cfg_ch.accept_threshold;
      if (finish) busy_r <= 1'b0;
      if (rsp_d.done) ldone_r[0] <= 1'b1;
      if (rsp_f.done) ldone_r[1] <= 1'b1;
      if (in_acc) begin
        case (in_ch.kind)
          KIND_TRAIN: begin
            busy_r <= 1'b1;
            if (full) begin
              ldone_r   <= 2'b11;
              status_r  <= STAT_DROPPED;
              cnt_out_r <= CntW'(acc_cnt_r);
            end else begin
              ldone_r   <= 2'b00;
              acc_cnt_r <= acc_cnt_r + 1'b1;
              status_r  <= STAT_TAKEN;
              cnt_out_r <= CntW'(acc_cnt_r + 1'b1);
            end
          end
          KIND_FIN: begin
            busy_r     <= 1'b1;
            ldone_r    <= 2'b00;
            prof_cnt_r <= acc_cnt_r;
            acc_cnt_r  <= '0;
            status_r   <= STAT_BUILT;
            cnt_out_r  <= CntW'(acc_cnt_r);
          end
          KIND_VERIFY: begin
            busy_r    <= 1'b1;
            ldone_r   <= 2'b00;
            status_r  <= STAT_SCORED;
            cnt_out_r <= CntW'(prof_cnt_r);
          end
          default: ;
        endcase
      end
    end
  end

  zpv_lane #(.CW(CW)) u_dwell_lane (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd_d),
    .n     (acc_cnt_r),
    .rsp   (rsp_d)
  );

  zpv_lane #(.CW(CW)) u_flight_lane (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd_f),
    .n     (acc_cnt_r),
    .rsp   (rsp_f)
  );

  zpv_merge u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .req          (mreq),
    .dwell_score  (rsp_d.score),
    .flight_score (rsp_f.score),
    .threshold    (thr_r),
    .can_load     (can_load),
    .out_ch       (out_ch)
  );

  // The training counter never passes the sample limit.
  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    acc_cnt_r <= CW'(MAX_SAMPLES))
    else $error("training count above limit");

  // A lane only reports completion for an item in work.
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (rsp_d.done || rsp_f.done) |-> busy_r)
    else $error("lane done while idle");

  // Each lane reports at most once per item.
  a_lane_once: assert property (@(posedge clk) disable iff (!rst_n)
    (rsp_d.done |-> !ldone_r[0]) and (rsp_f.done |-> !ldone_r[1]))
    else $error("lane reported twice");

  // Results other than a score carry zero score fields.
  a_unscored_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != STAT_SCORED) |->
      (out_ch.total_score == '0 && !out_ch.accepted))
    else $error("score fields set on unscored result");

endmodule
